// ===== rtl/pfv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfv_pkg
// Shared types, constants and helper functions of the pipe-separated
// payload validator: escape and UTF-8 decoder state, field codes, limits.
// ----------------------------------------------------------------------------
package pfv_pkg;

	// Default longest request id, in characters
	localparam int ID_MAX_LEN_DEF = 32;

	// Reset value of the payload length limit
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4096;

	// Saturation points of the running counters
	localparam logic [16:0] BYTE_COUNT_MAX = 17'h1FFFF;
	localparam logic [15:0] FIELD_MAX      = 16'hFFFF;

	// Field codes
	localparam logic [15:0] FIELD_VERSION = 16'd0;
	localparam logic [15:0] FIELD_ID      = 16'd1;
	localparam logic [15:0] FIELD_CMD     = 16'd2;

	// Character codes
	localparam logic [7:0] SEP_CHAR     = 8'h7C;
	localparam logic [7:0] PCT_CHAR     = 8'h25;
	localparam logic [7:0] VERSION_CHAR = 8'h31;
	localparam logic [7:0] PRINT_LO     = 8'h20;
	localparam logic [7:0] PRINT_HI     = 8'h7E;
	localparam logic [7:0] DEL_CHAR     = 8'h7F;

	// UTF-8 lead byte ranges
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	// Code point limits
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] CP_MIN_2B  = 21'h000080;
	localparam logic [20:0] CP_MIN_3B  = 21'h000800;
	localparam logic [20:0] CP_MIN_4B  = 21'h010000;

	// Escape phase: none, after '%', after the first hex digit
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_HIGH,
		ESC_LOW
	} esc_phase_t;

	// Minimum code point class of an open multi-byte sequence
	typedef enum logic [1:0] {
		MIN_NONE,
		MIN_2B,
		MIN_3B,
		MIN_4B
	} min_class_t;

	// Decoder state for fields from 3 on
	typedef struct packed {
		esc_phase_t esc;
		logic [3:0] hi_nib;
		logic [1:0] cont_left;
		logic [20:0] code;
		min_class_t min_cls;
	} pfv_dec_t;

	localparam pfv_dec_t DEC_CLEAR = '{ESC_NONE, 4'd0, 2'd0, 21'd0, MIN_NONE};

	// Hex digit value; bit 4 set marks a non-hex character
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = {1'b0, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = {1'b0, 4'(b - 8'h37)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	// Letters, digits, '_' and '-'
	function automatic logic is_id_char(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h5F || b == 8'h2D;
	endfunction

	// Smallest code point allowed for a sequence class
	function automatic logic [20:0] min_code(input min_class_t c);
		logic [20:0] m;
		unique case (c)
			MIN_2B: m = CP_MIN_2B;
			MIN_3B: m = CP_MIN_3B;
			default: m = CP_MIN_4B;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pfv_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfv_stream_if
// Valid/ready channels of the validator: payload bytes in, results out.
// ----------------------------------------------------------------------------
interface pfv_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pfv_result_if;
	logic valid;
	logic ready;
	logic [7:0] echo_byte;
	logic [15:0] field_number;
	logic is_separator;
	logic payload_done;
	logic accepted;

	modport source (output valid, output echo_byte, output field_number,
		output is_separator, output payload_done, output accepted, input ready);
	modport sink (input valid, input echo_byte, input field_number,
		input is_separator, input payload_done, input accepted, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfv_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfv_decode
// Next-state logic for one byte of a percent-encoded field: %XX escape
// tracking, then UTF-8 sequence checking of the decoded byte.
// ----------------------------------------------------------------------------
module pfv_decode (
	input  wire logic [7:0]        data_byte,
	input  wire pfv_pkg::pfv_dec_t cur,
	output pfv_pkg::pfv_dec_t      nxt,
	output logic                   bad
);
	import pfv_pkg::*;

	logic [4:0]  hex;
	logic [7:0]  u;
	logic        u_en;
	logic [20:0] code_sh;

	assign hex     = hex_value(data_byte);
	assign code_sh = {cur.code[14:0], u[5:0]};

	always_comb begin
		nxt  = cur;
		bad  = 1'b0;
		u_en = 1'b0;
		u    = data_byte;

		// Track the escape; a completed escape yields the decoded byte
		unique case (cur.esc)
			ESC_NONE: begin
				if (data_byte == PCT_CHAR) begin
					nxt.esc = ESC_HIGH;
				end else begin
					u_en = 1'b1;
				end
			end
			ESC_HIGH: begin
				if (hex[4]) begin
					bad     = 1'b1;
					nxt.esc = ESC_NONE;
				end else begin
					nxt.hi_nib = hex[3:0];
					nxt.esc    = ESC_LOW;
				end
			end
			default: begin
				nxt.esc = ESC_NONE;
				if (hex[4]) begin
					bad = 1'b1;
				end else begin
					u    = {cur.hi_nib, hex[3:0]};
					u_en = 1'b1;
				end
			end
		endcase

		// Check the decoded byte against the open UTF-8 sequence
		if (u_en) begin
			if (cur.cont_left == 2'd0) begin
				priority if (!u[7]) begin
					if (u < PRINT_LO || u == DEL_CHAR) bad = 1'b1;
				end else if (u >= LEAD2_LO && u <= LEAD2_HI) begin
					nxt.cont_left = 2'd1;
					nxt.code      = {16'd0, u[4:0]};
					nxt.min_cls   = MIN_2B;
				end else if (u >= LEAD3_LO && u <= LEAD3_HI) begin
					nxt.cont_left = 2'd2;
					nxt.code      = {17'd0, u[3:0]};
					nxt.min_cls   = MIN_3B;
				end else if (u >= LEAD4_LO && u <= LEAD4_HI) begin
					nxt.cont_left = 2'd3;
					nxt.code      = {18'd0, u[2:0]};
					nxt.min_cls   = MIN_4B;
				end else begin
					bad = 1'b1;
				end
			end else if (u[7:6] != 2'b10) begin
				bad           = 1'b1;
				nxt.cont_left = 2'd0;
			end else begin
				nxt.code      = code_sh;
				nxt.cont_left = cur.cont_left - 2'd1;
				// Sequence complete: reject overlong, surrogate, out of range
				if (cur.cont_left == 2'd1) begin
					if (code_sh < min_code(cur.min_cls) || code_sh > CP_MAX ||
						(code_sh >= SURR_LO && code_sh <= SURR_HI)) begin
						bad = 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pfv_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfv_tracker
// Running payload state: byte count, field index, position in field,
// per-field rules and the verdict on the last byte.
// ----------------------------------------------------------------------------
module pfv_tracker #(
	parameter int ID_MAX_LEN = pfv_pkg::ID_MAX_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic [15:0] max_payload,
	output logic [15:0]      field_cur,
	output logic             sep,
	output logic             ok
);
	import pfv_pkg::*;

	localparam int PosW = $clog2(ID_MAX_LEN + 2);
	localparam logic [PosW-1:0] PosSat = PosW'(ID_MAX_LEN + 1);
	localparam logic [PosW-1:0] PosMax = PosW'(ID_MAX_LEN);

	logic [16:0]     byte_count_q, bc_n;
	logic [15:0]     field_q, field_m;
	logic [PosW-1:0] pos_q, pos_m;
	logic            rej_q, rej_a, rej_m;
	logic            ver_q, ver_m;
	pfv_dec_t        dec_q, dec_m, dec_nxt;
	logic            dec_bad;

	// Rejection at the end of a field
	function automatic logic end_bad(input logic [15:0] f, input logic [PosW-1:0] p,
		input logic v, input pfv_dec_t d);
		logic r;
		priority if (f == FIELD_VERSION) begin
			r = !v;
		end else if (f == FIELD_ID) begin
			r = (p == '0) || (p > PosMax);
		end else if (f == FIELD_CMD) begin
			r = (p == '0);
		end else begin
			r = (d.esc != ESC_NONE) || (d.cont_left != 2'd0);
		end
		return r;
	endfunction

	pfv_decode u_dec (
		.data_byte (data_byte),
		.cur       (dec_q),
		.nxt       (dec_nxt),
		.bad       (dec_bad)
	);

	assign sep       = (data_byte == SEP_CHAR);
	assign field_cur = field_q;
	assign bc_n      = (byte_count_q != BYTE_COUNT_MAX) ? byte_count_q + 17'd1 : byte_count_q;
	assign rej_a     = rej_q || (bc_n > {1'b0, max_payload}) ||
		(data_byte < PRINT_LO) || (data_byte > PRINT_HI);

	// Apply the byte: close a field on a separator, otherwise check it
	always_comb begin
		field_m = field_q;
		pos_m   = pos_q;
		ver_m   = ver_q;
		dec_m   = dec_q;
		rej_m   = rej_a;
		if (sep) begin
			rej_m   = rej_a || end_bad(field_q, pos_q, ver_q, dec_q);
			pos_m   = '0;
			dec_m   = DEC_CLEAR;
			field_m = (field_q != FIELD_MAX) ? field_q + 16'd1 : field_q;
		end else begin
			priority if (field_q == FIELD_VERSION) begin
				ver_m = (pos_q == '0) && (data_byte == VERSION_CHAR);
			end else if (field_q == FIELD_ID) begin
				if (!is_id_char(data_byte)) rej_m = 1'b1;
			end else if (field_q == FIELD_CMD) begin
				if (data_byte < 8'h41 || data_byte > 8'h5A) rej_m = 1'b1;
			end else begin
				dec_m = dec_nxt;
				if (dec_bad) rej_m = 1'b1;
			end
			if (pos_q < PosSat) pos_m = pos_q + PosW'(1);
		end
	end

	// Verdict: close the final field and require three fields
	assign ok = last_byte && !(rej_m || end_bad(field_m, pos_m, ver_m, dec_m) ||
		field_m < FIELD_CMD);

	// Advance the state on each transfer; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			field_q      <= '0;
			pos_q        <= '0;
			rej_q        <= 1'b0;
			ver_q        <= 1'b0;
			dec_q        <= DEC_CLEAR;
		end else if (step) begin
			if (last_byte) begin
				byte_count_q <= '0;
				field_q      <= '0;
				pos_q        <= '0;
				rej_q        <= 1'b0;
				ver_q        <= 1'b0;
				dec_q        <= DEC_CLEAR;
			end else begin
				byte_count_q <= bc_n;
				field_q      <= field_m;
				pos_q        <= pos_m;
				rej_q        <= rej_m;
				ver_q        <= ver_m;
				dec_q        <= dec_m;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/percent_field_payload_validator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// percent_field_payload_validator_core
// Checks a pipe-separated payload byte by byte: version, request id,
// command, percent-encoded UTF-8 fields, length and character range.
// ----------------------------------------------------------------------------
//  channel     dir  handshake    payload
//  cfg         in   cfg_we       cfg_data = max_payload_bytes (16 bit)
//  byte_ch     in   valid/ready  data_byte, last_byte
//  result_ch   out  valid/ready  echo_byte, field_number, is_separator,
//                                payload_done, accepted
//
//  One byte per cycle sustained while the result channel does not stall; one result per
//  byte, registered through the input register, then the result register.
//  The state update for a byte is one pass of logic between the two registers.
//  byte_ch.ready drops only while both registers are full and the result stalls.
//  Reset clears the payload state and sets the length limit to 4096.
// ----------------------------------------------------------------------------
module percent_field_payload_validator_core #(
	parameter int ID_MAX_LEN = pfv_pkg::ID_MAX_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	pfv_byte_if.sink         byte_ch,
	pfv_result_if.source     result_ch
);
	import pfv_pkg::*;

	logic [15:0] max_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	logic [7:0]  echo_s2;
	logic [15:0] field_s2;
	logic        sep_s2;
	logic        done_s2;
	logic        acc_s2;
	logic        advance;
	logic [15:0] field_cur;
	logic        sep;
	logic        ok;

	// Move the held byte into the result register when it is free
	assign advance       = valid_s1 && (!valid_s2 || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	// Hold the length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data_byte;
			last_s1 <= byte_ch.last_byte;
		end
	end

	pfv_tracker #(
		.ID_MAX_LEN (ID_MAX_LEN)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.last_byte   (last_s1),
		.max_payload (max_q),
		.field_cur   (field_cur),
		.sep         (sep),
		.ok          (ok)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			echo_s2  <= byte_s1;
			field_s2 <= field_cur;
			sep_s2   <= sep;
			done_s2  <= last_s1;
			acc_s2   <= ok;
		end
	end

	assign result_ch.valid        = valid_s2;
	assign result_ch.echo_byte    = echo_s2;
	assign result_ch.field_number = field_s2;
	assign result_ch.is_separator = sep_s2;
	assign result_ch.payload_done = done_s2;
	assign result_ch.accepted     = acc_s2;

endmodule
`default_nettype wire

// ===== rtl/pfv_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfv_checker
// Port-level checks of the validator, bound to the top level.
// ----------------------------------------------------------------------------
module pfv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  echo_byte,
	input wire logic [15:0] field_number,
	input wire logic        is_separator,
	input wire logic        payload_done,
	input wire logic        accepted
);
	import pfv_pkg::*;

	// A stalled byte stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("byte transfer withdrawn while stalled");

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable(echo_byte) && $stable(field_number) && $stable(is_separator) &&
		$stable(accepted) && $stable(payload_done))
		else $error("result changed while stalled");

	// A verdict of accept only comes on a final byte of a three-field payload
	a_acc_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |->
		payload_done && field_number >= FIELD_CMD)
		else $error("accept outside a complete payload");

	// A final byte outside the printable range rejects the payload
	a_acc_print: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |->
		echo_byte >= PRINT_LO && echo_byte <= PRINT_HI)
		else $error("accept on a non-printable byte");

endmodule

bind percent_field_payload_validator_core pfv_checker u_pfv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_ch.valid),
	.in_ready     (byte_ch.ready),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.echo_byte    (result_ch.echo_byte),
	.field_number (result_ch.field_number),
	.is_separator (result_ch.is_separator),
	.payload_done (result_ch.payload_done),
	.accepted     (result_ch.accepted)
);
`default_nettype wire

// ===== tb/percent_field_payload_validator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_field_payload_validator_core_test
// Streams pipe-separated payloads into the validator under random sender
// bursts and receiver stalls, predicts the echo, field number, separator
// mark and verdict of every byte, and compares each result in order.
// ----------------------------------------------------------------------------
module percent_field_payload_validator_core_test;
	import pfv_pkg::*;

	localparam int          STALL_LIMIT  = 5000;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          HOLD_CYCLES  = 400;
	localparam int unsigned CP_EDGES [8] = '{'h80, 'h7FF, 'h800, 'hD7FF,
		'hE000, 'hFFFF, 'h10000, 'h10FFFF};
	localparam logic [7:0]  RAW_EDGES [4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};

	typedef struct packed {
		logic [7:0]  echo;
		logic [15:0] fnum;
		logic        sep;
		logic        done;
		logic        ok;
	} echo_t;

	// Running payload state and verdict prediction, plus the pending echoes
	class payload_verdict_model;
		logic [15:0] max_payload;
		logic [16:0] byte_total;
		logic [15:0] field_idx;
		logic [5:0]  field_pos;
		logic        rejected;
		logic        version_ok;
		esc_phase_t  esc;
		logic [3:0]  hi_nib;
		logic [1:0]  cont_left;
		logic [20:0] code_point;
		min_class_t  min_cls;
		echo_t       expected [$];
		int          mismatches;

		function new();
			max_payload = MAX_PAYLOAD_RST;
			mismatches = 0;
			clear_payload();
		endfunction

		function void set_limit(logic [15:0] v);
			max_payload = v;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void clear_payload();
			byte_total = '0;
			field_idx = '0;
			version_ok = 1'b0;
			rejected = 1'b0;
			close_decoder();
		endfunction

		function void close_decoder();
			field_pos = '0;
			esc = ESC_NONE;
			hi_nib = '0;
			cont_left = '0;
			code_point = '0;
			min_cls = MIN_NONE;
		endfunction

		// Decode one byte of a percent field as UTF-8
		function void utf8_step(logic [7:0] b);
			logic [20:0] floor_cp;
			if (cont_left == 0) begin
				if (b < 8'h80) begin
					if (b < PRINT_LO || b == DEL_CHAR) rejected = 1'b1;
				end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					cont_left = 2'd1;
					code_point = {16'd0, b[4:0]};
					min_cls = MIN_2B;
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					cont_left = 2'd2;
					code_point = {17'd0, b[3:0]};
					min_cls = MIN_3B;
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					cont_left = 2'd3;
					code_point = {18'd0, b[2:0]};
					min_cls = MIN_4B;
				end else begin
					rejected = 1'b1;
				end
				return;
			end
			if (b[7:6] != 2'b10) begin
				rejected = 1'b1;
				cont_left = '0;
				return;
			end
			code_point = {code_point[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 0) begin
				case (min_cls)
					MIN_2B: floor_cp = 21'h80;
					MIN_3B: floor_cp = 21'h800;
					default: floor_cp = 21'h10000;
				endcase
				if (code_point < floor_cp || code_point > 21'h10FFFF ||
					(code_point >= 21'hD800 && code_point <= 21'hDFFF))
					rejected = 1'b1;
			end
		endfunction

		// Handle %XX escapes, then hand decoded bytes to the UTF-8 check
		function void escape_step(logic [7:0] b);
			logic [4:0] nib;
			if (esc == ESC_NONE) begin
				if (b == PCT_CHAR) esc = ESC_HIGH;
				else utf8_step(b);
				return;
			end
			if (b >= "0" && b <= "9") nib = {1'b0, 4'(b - "0")};
			else if (b >= "a" && b <= "f") nib = {1'b0, 4'(b - "a" + 8'd10)};
			else if (b >= "A" && b <= "F") nib = {1'b0, 4'(b - "A" + 8'd10)};
			else nib = 5'h10;
			if (nib[4]) begin
				rejected = 1'b1;
				esc = ESC_NONE;
			end else if (esc == ESC_HIGH) begin
				hi_nib = nib[3:0];
				esc = ESC_LOW;
			end else begin
				esc = ESC_NONE;
				utf8_step({hi_nib, nib[3:0]});
			end
		endfunction

		function void field_byte(logic [15:0] f, logic [7:0] b);
			logic id_char;
			id_char = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
				(b >= "0" && b <= "9") || b == "_" || b == "-";
			if (f == FIELD_VERSION) version_ok = (field_pos == 0 && b == VERSION_CHAR);
			else if (f == FIELD_ID) begin
				if (!id_char) rejected = 1'b1;
			end else if (f == FIELD_CMD) begin
				if (b < "A" || b > "Z") rejected = 1'b1;
			end else escape_step(b);
			if (field_pos < ID_MAX_LEN_DEF + 1) field_pos = field_pos + 6'd1;
		endfunction

		function void close_field(logic [15:0] f);
			if (f == FIELD_VERSION) begin
				if (!version_ok) rejected = 1'b1;
			end else if (f == FIELD_ID) begin
				if (field_pos == 0 || field_pos > ID_MAX_LEN_DEF) rejected = 1'b1;
			end else if (f == FIELD_CMD) begin
				if (field_pos == 0) rejected = 1'b1;
			end else if (esc != ESC_NONE || cont_left != 0) begin
				rejected = 1'b1;
			end
			close_decoder();
		endfunction

		// Advance the state for one transferred byte and queue its echo
		function void note_byte(logic [7:0] b, logic fin);
			echo_t want;
			want.echo = b;
			want.fnum = field_idx;
			want.sep = (b == SEP_CHAR);
			want.done = fin;
			want.ok = 1'b0;
			if (byte_total != BYTE_COUNT_MAX) byte_total = byte_total + 17'd1;
			if (byte_total > {1'b0, max_payload}) rejected = 1'b1;
			if (b < PRINT_LO || b > PRINT_HI) rejected = 1'b1;
			if (want.sep) begin
				close_field(want.fnum);
				if (field_idx != FIELD_MAX) field_idx = field_idx + 16'd1;
			end else begin
				field_byte(want.fnum, b);
			end
			if (fin) begin
				close_field(field_idx);
				if (field_idx < FIELD_CMD) rejected = 1'b1;
				want.ok = !rejected;
				clear_payload();
			end
			expected.insert(expected.size(), want);
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_echo(echo_t got);
			echo_t want;
			if (expected.size() == 0) begin
				report_mismatch($sformatf("result with none pending, echo_byte %02h", got.echo));
				return;
			end
			want = expected.pop_front();
			if (got.echo !== want.echo)
				report_mismatch($sformatf("echo_byte %h, want %h", got.echo, want.echo));
			if (got.fnum !== want.fnum)
				report_mismatch($sformatf("field_number %0d, want %0d", got.fnum, want.fnum));
			if (got.sep !== want.sep)
				report_mismatch($sformatf("is_separator %b, want %b", got.sep, want.sep));
			if (got.done !== want.done)
				report_mismatch($sformatf("payload_done %b, want %b", got.done, want.done));
			if (got.ok !== want.ok)
				report_mismatch($sformatf("accepted %b, want %b", got.ok, want.ok));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_data;

	pfv_byte_if byte_ch ();
	pfv_result_if result_ch ();

	percent_field_payload_validator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.byte_ch(byte_ch),
		.result_ch(result_ch)
	);

	payload_verdict_model sb;
	logic [7:0] payload [$];
	string id_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
	int unsigned bytes_sent;
	int burst_left;
	bit hold_request;
	int idle_cycles;

	always #4 clk = ~clk;

	// Compare every result transfer with the oldest pending echo
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			sb.check_echo('{result_ch.echo_byte, result_ch.field_number,
				result_ch.is_separator, result_ch.payload_done, result_ch.accepted});
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Receiver: mix of open stretches, short stalls, random ready, one long hold
	initial begin
		result_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						result_ch.ready <= 1'b1;
						repeat ($urandom_range(5, 60)) @(posedge clk);
					end
					1: repeat ($urandom_range(4, 20)) begin
						result_ch.ready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
					2: begin
						result_ch.ready <= 1'b0;
						repeat ($urandom_range(1, 12)) @(posedge clk);
					end
					default: repeat ($urandom_range(4, 30)) begin
						result_ch.ready <= ($urandom_range(0, 3) != 0);
						@(posedge clk);
					end
				endcase
			end
		end
	end

	// Offer one byte, with a random gap at each burst boundary; return on transfer
	task automatic send_byte(logic [7:0] b, logic fin);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 24);
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		burst_left--;
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= fin;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_payload();
		foreach (payload[i]) send_byte(payload[i], i == payload.size() - 1);
	endtask

	// Drop valid and wait until every echo has come back
	task automatic settle();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	// Append one byte to the payload under construction
	function automatic void put_byte(logic [7:0] b);
		payload.insert(payload.size(), b);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endfunction

	task automatic send_text(string s);
		payload.delete();
		put_str(s);
		send_payload();
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10) return "0" + n;
		return (($urandom_range(0, 1) != 0) ? "A" : "a") + n - 8'd10;
	endfunction

	function automatic void put_escape(logic [7:0] b);
		put_byte(PCT_CHAR);
		put_byte(hex_char(b[7:4]));
		put_byte(hex_char(b[3:0]));
	endfunction

	// Encode a code point as escaped UTF-8
	function automatic void put_cp(int unsigned cp);
		if (cp < 'h80) begin
			put_escape(cp[7:0]);
		end else if (cp < 'h800) begin
			put_escape(8'hC0 | 8'(cp >> 6));
			put_escape(8'h80 | 8'(cp & 'h3F));
		end else if (cp < 'h10000) begin
			put_escape(8'hE0 | 8'(cp >> 12));
			put_escape(8'h80 | 8'((cp >> 6) & 'h3F));
			put_escape(8'h80 | 8'(cp & 'h3F));
		end else begin
			put_escape(8'hF0 | 8'(cp >> 18));
			put_escape(8'h80 | 8'((cp >> 12) & 'h3F));
			put_escape(8'h80 | 8'((cp >> 6) & 'h3F));
			put_escape(8'h80 | 8'(cp & 'h3F));
		end
	endfunction

	function automatic int unsigned random_cp();
		case ($urandom_range(0, 4))
			0: return $urandom_range('h20, 'h7E);
			1: return $urandom_range('h80, 'h7FF);
			2: return ($urandom_range(0, 1) != 0) ? $urandom_range('h800, 'hD7FF)
				: $urandom_range('hE000, 'hFFFF);
			3: return $urandom_range('h10000, 'h10FFFF);
			default: return CP_EDGES[$urandom_range(0, 7)];
		endcase
	endfunction

	// Printable byte that is neither an escape nor a separator
	function automatic void put_plain();
		logic [7:0] b;
		do b = 8'($urandom_range(PRINT_LO, PRINT_HI));
		while (b == PCT_CHAR || b == SEP_CHAR);
		put_byte(b);
	endfunction

	function automatic void put_fault();
		case ($urandom_range(0, 7))
			0: put_escape(8'($urandom_range(0, 255)));
			1: put_str("%C0%80");
			2: put_str("%E0%80%80");
			3: put_str("%ED%A0%80");
			4: put_str("%F4%90%80%80");
			5: put_str("%E2%82");
			6: begin
				put_byte(PCT_CHAR);
				if ($urandom_range(0, 1) != 0) put_byte(hex_char(4'($urandom_range(0, 15))));
				put_plain();
			end
			default: put_byte(PCT_CHAR);
		endcase
	endfunction

	// Mostly well-formed requests with random content; some noise and damage
	function automatic void build_payload();
		int n;
		payload.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
			return;
		end
		case ($urandom_range(0, 15))
			0: put_str("2");
			1: put_str("11");
			2: ;
			default: put_str("1");
		endcase
		put_byte(SEP_CHAR);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 33) : $urandom_range(1, 12);
		if ($urandom_range(0, 39) == 0) n = 0;
		repeat (n) begin
			if ($urandom_range(0, 39) == 0) put_plain();
			else put_byte(id_alphabet[$urandom_range(0, id_alphabet.len() - 1)]);
		end
		if ($urandom_range(0, 19) == 0) return;
		put_byte(SEP_CHAR);
		n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 29) == 0) put_plain();
			else put_byte(8'($urandom_range("A", "Z")));
		end
		repeat ($urandom_range(0, 3)) begin
			put_byte(SEP_CHAR);
			repeat ($urandom_range(0, 6)) begin
				n = $urandom_range(0, 19);
				if (n < 14) put_plain();
				else if (n < 19) put_cp(random_cp());
				else put_fault();
			end
		end
		if ($urandom_range(0, 9) == 0) put_byte(SEP_CHAR);
		if ($urandom_range(0, 11) == 0)
			payload[$urandom_range(0, payload.size() - 1)] = 8'($urandom_range(0, 255));
	endfunction

	task automatic run_random(int unsigned n);
		int unsigned stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) begin
			build_payload();
			send_payload();
		end
	endtask

	// Header, a run of separators, then an optional tail
	task automatic send_separator_run(int unsigned seps, string tail);
		string head;
		head = "1|a|B";
		for (int i = 0; i < head.len(); i++) send_byte(head[i], 1'b0);
		for (int unsigned k = 0; k < seps; k++)
			send_byte(SEP_CHAR, tail.len() == 0 && k == seps - 1);
		for (int i = 0; i < tail.len(); i++) send_byte(tail[i], i == tail.len() - 1);
	endtask

	initial begin
		string directed_cases [$];
		directed_cases = '{
			"1|a|B", "1|a|B|", "1|ab", "2|a|B", "11|a|B", "|a|B", "|", "1",
			"1|abcdefghijklmnopqrstuvwxyzABCD-_|CMD",
			"1|abcdefghijklmnopqrstuvwxyzABCD-_9|CMD",
			"1||B", "1|a|b", "1|a||x",
			"1|Az_09-|GET|%41%c3%A9 x|%f0%9F%98%80",
			"1|a|B|%4G|ok", "1|a|B|%4", "1|a|B|%C3", "1|a|B|%C0%80",
			"1|a|B|%ED%A0%80", "1|a|B|%F4%90%80%80", "1|a|B|%01",
			"1|a|B|%7F", "1|a|B|%C3A|x", "2|a|B|%41|zz"
		};
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		bytes_sent = 0;
		burst_left = 0;
		hold_request = 1'b0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases at the reset limit
		foreach (directed_cases[i]) send_text(directed_cases[i]);
		foreach (RAW_EDGES[i]) begin
			payload.delete();
			put_str("1|a|B|");
			put_byte(RAW_EDGES[i]);
			send_payload();
		end

		// Random traffic under one long receiver hold
		hold_request = 1'b1;
		run_random(400);

		// Zero limit rejects everything
		write_limit(16'd0);
		send_text("1|a|B");
		run_random(80);

		write_limit(16'd1);
		send_text("1|a|B");
		run_random(80);

		// Widest limit, then long runs of empty fields
		write_limit(16'hFFFF);
		send_separator_run(40, "");
		send_separator_run(30, "%41");
		run_random(150);

		write_limit(16'($urandom_range(8, 40)));
		run_random(150);

		write_limit(MAX_PAYLOAD_RST);
		run_random(150);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
